[design/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[design/llsp_pkg.sv]
// Types and codes for the least loaded server picker.
`default_nettype none

package llsp_pkg;

    localparam int ID_W     = 16;
    localparam int TYPE_W   = 16;
    localparam int LOAD_W   = 32;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int DATA_W   = ID_W + TYPE_W + LOAD_W + HANDLE_W;

    typedef logic [ID_W-1:0]     t_id;
    typedef logic [TYPE_W-1:0]   t_type;
    typedef logic [LOAD_W-1:0]   t_load;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [STATUS_W-1:0] t_status;

    // Item kinds
    localparam logic KIND_SYNC = 1'b0;
    localparam logic KIND_PICK = 1'b1;

    // Result status codes
    localparam t_status ST_UPDATED  = 3'd0;
    localparam t_status ST_INSERTED = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_PICKED   = 3'd3;
    localparam t_status ST_NONE     = 3'd4;

    localparam t_load LOAD_MAX = '1;

endpackage

`default_nettype wire

[design/least_loaded_server_picker.sv]
// Least loaded server picker: server table, sequential scan and write-back.
`default_nettype none

`include "assert_macros.svh"

// Keeps a table of up to MAX_SERVERS servers. A sync item (tuser 0) updates
// the load and handle of a known id or inserts the server in the lowest free
// slot; a pick item (tuser 1) returns the matching server with the least load
// (ties to the lowest id) and bumps its load, saturating. Each item produces
// one result transfer. The table is scanned through its single read port, one
// entry per cycle, with registered read data, followed by a write-back step; the
// next item is taken the cycle after the result has been transferred. The table
// is empty after reset through per-entry valid bits; no clearing pass is needed.
module least_loaded_server_picker
    import llsp_pkg::*;
#(
    parameter int MAX_SERVERS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    // server_id[15:0], type_mask[31:16], load_count[63:32], conn_handle[79:64]
    input  wire  [DATA_W-1:0] s_axis_tdata,
    // kind[0]
    input  wire               s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    // picked_id[15:0], picked_type[31:16], picked_load[63:32], picked_handle[79:64]
    output logic [DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [STATUS_W-1:0] m_axis_tuser
);

    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW = $clog2(MAX_SERVERS + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(MAX_SERVERS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    // table storage
    t_id     mem_id     [MAX_SERVERS];
    t_type   mem_type   [MAX_SERVERS];
    t_load   mem_load   [MAX_SERVERS];
    t_handle mem_handle [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] r_vld;

    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_cidx;
    logic          r_cen;

    // captured item
    logic    r_kind;
    t_id     r_in_id;
    t_type   r_in_type;
    t_load   r_in_load;
    t_handle r_in_handle;

    // registered read data
    t_id     r_rd_id;
    t_type   r_rd_type;
    t_load   r_rd_load;
    t_handle r_rd_handle;

    // scan results
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_free_ok;
    logic [IW-1:0] r_free_idx;
    logic          r_found;
    logic [IW-1:0] r_best_idx;
    t_id           r_best_id;
    t_type         r_best_type;
    t_load         r_best_load;
    t_handle       r_best_handle;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [DATA_W-1:0]   r_out_data;

    logic          in_fire;
    logic          out_fire;
    logic          rd_en;
    logic          c_live;
    logic          c_match;
    logic          c_free;
    logic          c_cand;
    logic          c_better;
    logic          in_write;
    logic          w_ins;
    logic          w_upd;
    logic          w_pick;
    logic [IW-1:0] w_addr;
    t_load         w_load;
    t_load         best_inc;

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    assign rd_en = (r_state == S_SCAN) && (r_cnt < LAST_CNT);

    // compare stage on the entry read in the previous cycle
    always_comb begin
        c_live   = r_cen && r_vld[r_cidx];
        c_match  = c_live && (r_rd_id == r_in_id);
        c_free   = r_cen && !r_vld[r_cidx];
        c_cand   = c_live && ((r_rd_type & r_in_type) != '0);
        c_better = !r_found || (r_rd_load < r_best_load) ||
                   ((r_rd_load == r_best_load) && (r_rd_id < r_best_id));
    end

    // write-back decode
    always_comb begin
        in_write = (r_state == S_WRITE);
        w_upd    = in_write && (r_kind == KIND_SYNC) && r_hit;
        w_ins    = in_write && (r_kind == KIND_SYNC) && !r_hit && r_free_ok;
        w_pick   = in_write && (r_kind == KIND_PICK) && r_found;
        best_inc = (r_best_load == LOAD_MAX) ? LOAD_MAX : r_best_load + 1'b1;
        priority if (w_upd) begin
            w_addr = r_hit_idx;
            w_load = r_in_load;
        end else if (w_ins) begin
            w_addr = r_free_idx;
            w_load = r_in_load;
        end else begin
            w_addr = r_best_idx;
            w_load = best_inc;
        end
    end

    // table memories: one read port during scan, one write port at write-back
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_id <= mem_id[r_cnt[IW-1:0]];
        end
        if (w_ins) begin
            mem_id[w_addr] <= r_in_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_type <= mem_type[r_cnt[IW-1:0]];
        end
        if (w_ins) begin
            mem_type[w_addr] <= r_in_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_load <= mem_load[r_cnt[IW-1:0]];
        end
        if (w_ins || w_upd || w_pick) begin
            mem_load[w_addr] <= w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_handle <= mem_handle[r_cnt[IW-1:0]];
        end
        if (w_ins || w_upd) begin
            mem_handle[w_addr] <= r_in_handle;
        end
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cen       <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cen <= 1'b0;
                    if (in_fire) begin
                        r_state   <= S_SCAN;
                        r_cnt     <= '0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_found   <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_cen <= rd_en;
                    if (rd_en) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= S_WRITE;
                    end
                    if (r_kind == KIND_SYNC) begin
                        if (c_match && !r_hit) begin
                            r_hit <= 1'b1;
                        end
                        if (c_free && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                        end
                    end else if (c_cand && c_better) begin
                        r_found <= 1'b1;
                    end
                end
                S_WRITE: begin
                    r_cen       <= 1'b0;
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    if (w_ins) begin
                        r_vld[r_free_idx] <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cidx <= r_cnt[IW-1:0];
        if (in_fire) begin
            r_kind      <= s_axis_tuser;
            r_in_id     <= s_axis_tdata[ID_W-1:0];
            r_in_type   <= s_axis_tdata[ID_W+TYPE_W-1:ID_W];
            r_in_load   <= s_axis_tdata[ID_W+TYPE_W+LOAD_W-1:ID_W+TYPE_W];
            r_in_handle <= s_axis_tdata[DATA_W-1:ID_W+TYPE_W+LOAD_W];
        end
        if (r_state == S_SCAN) begin
            if (r_kind == KIND_SYNC) begin
                if (c_match && !r_hit) begin
                    r_hit_idx <= r_cidx;
                end
                if (c_free && !r_free_ok) begin
                    r_free_idx <= r_cidx;
                end
            end else if (c_cand && c_better) begin
                r_best_idx    <= r_cidx;
                r_best_id     <= r_rd_id;
                r_best_type   <= r_rd_type;
                r_best_load   <= r_rd_load;
                r_best_handle <= r_rd_handle;
            end
        end
        if (in_write) begin
            if (r_kind == KIND_SYNC) begin
                r_out_data <= '0;
                priority if (r_hit) begin
                    r_out_status <= ST_UPDATED;
                end else if (r_free_ok) begin
                    r_out_status <= ST_INSERTED;
                end else begin
                    r_out_status <= ST_FULL;
                end
            end else if (r_found) begin
                r_out_status <= ST_PICKED;
                r_out_data   <= {r_best_handle, best_inc, r_best_type, r_best_id};
            end else begin
                r_out_status <= ST_NONE;
                r_out_data   <= '0;
            end
        end
    end

    // a transfer starts the scan at entry zero
    `ASSERT_CLK(a_scan_start, in_fire |=> (r_state == S_SCAN) && (r_cnt == '0),
        "scan did not start after input transfer")
    // write-back only follows a finished scan
    `ASSERT_CLK(a_write_after_scan,
        (r_state == S_WRITE) |-> ($past(r_state) == S_SCAN) && !$past(rd_en),
        "write-back entered before scan finished")
    // a pick never changes the set of occupied entries
    `ASSERT_CLK(a_pick_keeps_valid,
        (in_write && (r_kind == KIND_PICK)) |=> $stable(r_vld),
        "pick changed table occupancy")
    // results without a picked server carry zero data
    `ASSERT_CLK(a_zero_data,
        (r_out_valid && (r_out_status != ST_PICKED)) |-> (r_out_data == '0),
        "non-pick result carries data")

endmodule

`default_nettype wire

[bench/tb_least_loaded_server_picker.sv]
// Testbench for least_loaded_server_picker: directed and random sync/pick traffic, scoreboarded.
module tb_least_loaded_server_picker;
    import llsp_pkg::*;

    localparam int NUM_SLOTS      = 16;
    localparam int RANDOM_ITEMS   = 400;
    localparam int POOL_SIZE      = 20;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 3 * (NUM_SLOTS + 3);
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic    kind;
        t_id     id;
        t_type   mask;
        t_load   load;
        t_handle handle;
        bit      drain;     // hold this item until every reply is back
    } t_server_req;

    typedef struct {
        t_status status;
        t_id     id;
        t_type   srv_type;
        t_load   load;
        t_handle handle;
    } t_server_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tuser = KIND_SYNC;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    t_server_req   request_queue[$];
    t_server_reply expected_replies[$];

    // Shadow copy of the server table
    logic    tbl_valid  [NUM_SLOTS];
    t_id     tbl_id     [NUM_SLOTS];
    t_type   tbl_type   [NUM_SLOTS];
    t_load   tbl_load   [NUM_SLOTS];
    t_handle tbl_handle [NUM_SLOTS];

    int items_sent = 0;
    int results_seen = 0;
    int fail_cnt = 0;
    int idle_cycles = 0;
    int status_seen [5];
    bit sending = 1'b0;
    int send_gap = 0;
    int rx_stall = 0;
    bit rx_ready = 1'b0;

    least_loaded_server_picker #(
        .MAX_SERVERS(NUM_SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT) begin
            $display("mismatch %0d: %s", fail_cnt, msg);
        end
    endtask

    task automatic add_request(input logic kind, input t_id id, input t_type mask,
                               input t_load load, input t_handle handle, input bit drain);
        t_server_req r;
        r.kind   = kind;
        r.id     = id;
        r.mask   = mask;
        r.load   = load;
        r.handle = handle;
        r.drain  = drain;
        request_queue.push_back(r);
    endtask

    // No wait in one stretch of 40 transfers out of every 120, random waits otherwise
    function automatic int draw_gap(input int n);
        return (((n / 40) % 3) == 1) ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic t_type rand_type_bits();
        case ($urandom_range(0, 3))
            0: return t_type'(1) << $urandom_range(0, TYPE_W - 1);
            1: return t_type'($urandom);
            2: return (t_type'(1) << $urandom_range(0, TYPE_W - 1)) |
                      (t_type'(1) << $urandom_range(0, TYPE_W - 1));
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    // Applies one item to the shadow table and returns the reply it should get
    function automatic t_server_reply predict_reply(input logic kind, input t_id id,
                                                    input t_type mask, input t_load load,
                                                    input t_handle handle);
        t_server_reply r;
        int free_slot;
        int best;
        bit found;
        r = '{status: ST_NONE, id: '0, srv_type: '0, load: '0, handle: '0};
        free_slot = -1;
        best = -1;
        found = 1'b0;
        if (kind == KIND_SYNC) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (tbl_valid[i]) begin
                    if (!found && tbl_id[i] == id) begin
                        found = 1'b1;
                        tbl_load[i] = load;
                        tbl_handle[i] = handle;
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (found) begin
                r.status = ST_UPDATED;
            end else if (free_slot < 0) begin
                r.status = ST_FULL;
            end else begin
                tbl_valid[free_slot]  = 1'b1;
                tbl_id[free_slot]     = id;
                tbl_type[free_slot]   = mask;
                tbl_load[free_slot]   = load;
                tbl_handle[free_slot] = handle;
                r.status = ST_INSERTED;
            end
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (tbl_valid[i] && (tbl_type[i] & mask) != '0) begin
                    if (best < 0 || tbl_load[i] < tbl_load[best] ||
                        (tbl_load[i] == tbl_load[best] && tbl_id[i] < tbl_id[best])) begin
                        best = i;
                    end
                end
            end
            if (best >= 0) begin
                if (tbl_load[best] != LOAD_MAX) begin
                    tbl_load[best] = tbl_load[best] + 1'b1;
                end
                r.status   = ST_PICKED;
                r.id       = tbl_id[best];
                r.srv_type = tbl_type[best];
                r.load     = tbl_load[best];
                r.handle   = tbl_handle[best];
            end
        end
        return r;
    endfunction

    // Driver: presents queued items, waiting a drawn gap between transfers
    always @(posedge i_clk) begin : drive
        t_server_req nxt;
        if (!i_rst_n) begin
            sending = 1'b0;
            send_gap = 0;
            s_axis_tvalid <= 1'b0;
        end else begin
            if (sending && s_axis_tready) begin
                sending = 1'b0;
                items_sent++;
                send_gap = draw_gap(items_sent);
            end
            if (!sending) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_queue.size() > 0 &&
                             !(request_queue[0].drain && items_sent != results_seen)) begin
                    nxt = request_queue.pop_front();
                    s_axis_tdata <= {nxt.handle, nxt.load, nxt.mask, nxt.id};
                    s_axis_tuser <= nxt.kind;
                    sending = 1'b1;
                end
            end
            s_axis_tvalid <= sending;
        end
    end

    // Result side backpressure; the stall only runs down while a result waits
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall = draw_gap(0);
        end else if (m_axis_tvalid && rx_ready) begin
            rx_stall = draw_gap(results_seen + 1);
        end else if (m_axis_tvalid && rx_stall > 0) begin
            rx_stall--;
        end
        rx_ready = (rx_stall == 0);
        m_axis_tready <= rx_ready;
    end

    // Monitor: predicts on each input transfer, checks each result transfer
    always @(posedge i_clk) begin : monitor
        t_server_reply got;
        t_server_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                tbl_valid[i] = 1'b0;
            end
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_replies.push_back(predict_reply(s_axis_tuser, s_axis_tdata[15:0],
                    s_axis_tdata[31:16], s_axis_tdata[63:32], s_axis_tdata[79:64]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status   = m_axis_tuser;
                got.id       = m_axis_tdata[15:0];
                got.srv_type = m_axis_tdata[31:16];
                got.load     = m_axis_tdata[63:32];
                got.handle   = m_axis_tdata[79:64];
                results_seen <= results_seen + 1;
                if (got.status < 5) begin
                    status_seen[got.status]++;
                end
                if (expected_replies.size() == 0) begin
                    note_fail($sformatf("result %0d with no item pending, status %0d",
                                        results_seen, got.status));
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status)
                        note_fail($sformatf("result %0d status exp %0d got %0d",
                                            results_seen, want.status, got.status));
                    if (got.id !== want.id)
                        note_fail($sformatf("result %0d id exp %h got %h",
                                            results_seen, want.id, got.id));
                    if (got.srv_type !== want.srv_type)
                        note_fail($sformatf("result %0d type exp %h got %h",
                                            results_seen, want.srv_type, got.srv_type));
                    if (got.load !== want.load)
                        note_fail($sformatf("result %0d load exp %h got %h",
                                            results_seen, want.load, got.load));
                    if (got.handle !== want.handle)
                        note_fail($sformatf("result %0d handle exp %h got %h",
                                            results_seen, want.handle, got.handle));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_id   id_pool [POOL_SIZE];
        t_id   rid;
        t_load rload;
        logic  rkind;
        for (int i = 0; i < 5; i++) begin
            status_seen[i] = 0;
        end

        // Directed: empty table, extremes, saturation, tie on load, update, zero type
        add_request(KIND_PICK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_request(KIND_SYNC, 16'h0000, 16'hFFFE, 32'h0000_0000, 16'h0000, 1'b0);
        add_request(KIND_SYNC, 16'hFFFF, 16'h0001, 32'hFFFF_FFFE, 16'hFFFF, 1'b0);
        add_request(KIND_PICK, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0);
        add_request(KIND_PICK, 16'h1234, 16'h0001, 32'h0000_0000, 16'h0000, 1'b0);
        add_request(KIND_PICK, 16'h0000, 16'h0001, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_request(KIND_PICK, 16'h0000, 16'hFFFF, 32'h0000_0000, 16'h0000, 1'b0);
        add_request(KIND_SYNC, 16'h0020, 16'h0001, 32'd5, 16'h0001, 1'b0);
        add_request(KIND_SYNC, 16'h0003, 16'h0001, 32'd5, 16'h0002, 1'b0);
        add_request(KIND_PICK, 16'h0000, 16'h0001, 32'h0000_0000, 16'h0000, 1'b0);
        add_request(KIND_SYNC, 16'h0020, 16'h1234, 32'h0000_0000, 16'hBEEF, 1'b0);
        add_request(KIND_PICK, 16'h0000, 16'h0001, 32'h0000_0000, 16'h0000, 1'b0);
        add_request(KIND_SYNC, 16'h1000, 16'h0000, 32'h0000_0000, 16'h5555, 1'b0);
        add_request(KIND_PICK, 16'hFFFF, 16'h8000, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_request(KIND_SYNC, 16'h0000, 16'hAAAA, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        add_request(KIND_PICK, 16'h0000, 16'h0002, 32'h0000_0000, 16'h0000, 1'b1);

        // Random: mostly ids from a small pool so updates and picks hit real
        // entries; the table fills up partway through and stays full
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            id_pool[i] = t_id'($urandom);
        end
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            rkind = $urandom_range(0, 1) ? KIND_PICK : KIND_SYNC;
            rid = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : t_id'($urandom);
            case ($urandom_range(0, 3))
                0: rload = $urandom_range(0, 3);
                1: rload = $urandom;
                2: rload = LOAD_MAX - $urandom_range(0, 2);
                default: rload = $urandom_range(0, 20);
            endcase
            add_request(rkind, rid, rand_type_bits(), rload, t_handle'($urandom),
                        (k % 100) == 50);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (request_queue.size() != 0 || sending || items_sent != results_seen);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_replies.size() != 0) begin
            note_fail($sformatf("%0d replies never arrived", expected_replies.size()));
        end

        $display("covered %0d items: %0d inserted, %0d updated, %0d table full",
                 items_sent, status_seen[ST_INSERTED], status_seen[ST_UPDATED],
                 status_seen[ST_FULL]);
        $display("picks: %0d served, %0d with no match; %0d check failures",
                 status_seen[ST_PICKED], status_seen[ST_NONE], fail_cnt);
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
